>>> rtl/fpr_pkg.sv
// ----------------------------------------------------------------------------
// Framed packet receiver package
// Word types, kind codes and frame constants shared by the receiver files.
// ----------------------------------------------------------------------------
package fpr_pkg;

    localparam int unsigned FRAME_LIMIT = 306;
    localparam int unsigned POS_W       = 9;
    localparam int unsigned LEN_W       = 15;
    localparam int unsigned DIGITS      = 4;

    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_CR   = 8'h0d;
    localparam logic [7:0] CH_LF   = 8'h0a;

    localparam logic [POS_W-1:0] POS_FIRST_DIGIT = POS_W'(2);
    localparam logic [POS_W-1:0] POS_LAST_DIGIT  = POS_W'(5);
    localparam logic [POS_W-1:0] POS_DATA        = POS_W'(6);
    localparam logic [POS_W-1:0] POS_LIMIT       = POS_W'(FRAME_LIMIT);
    localparam logic [POS_W-1:0] CHECK_MAX       = POS_W'(5);

    typedef enum logic [2:0] {
        KIND_BUSY    = 3'd0,
        KIND_HASH1   = 3'd1,
        KIND_HASH2   = 3'd2,
        KIND_DIGIT   = 3'd3,
        KIND_DATA    = 3'd4,
        KIND_CHECK   = 3'd5,
        KIND_RESET   = 3'd6,
        KIND_RELEASE = 3'd7
    } t_kind;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_value;
    } t_in_word;

    typedef struct packed {
        t_kind            kind_code;
        logic [7:0]       out_value;
        logic [POS_W-1:0] slot_index;
        logic [LEN_W-1:0] declared_length;
        logic             frame_done;
        logic             check_overflow;
    } t_out_word;

endpackage

>>> rtl/fpr_if.sv
// ----------------------------------------------------------------------------
// Framed packet receiver channels
// Valid/ready channels for received bytes and for classified results.
// ----------------------------------------------------------------------------
interface fpr_in_if;
    logic              valid;
    logic              ready;
    fpr_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fpr_out_if;
    logic               valid;
    logic               ready;
    fpr_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/framed_packet_receiver.sv
// ----------------------------------------------------------------------------
// Framed packet receiver
// Classifies UART bytes of "##", four length digits, data, check, CR LF frames.
// ----------------------------------------------------------------------------
// Every word on i_rx gives exactly one result word on o_res, in order. A word
// passes through an input register and is classified on its way into the
// result register, so one word is taken per cycle while o_res is not stalled,
// and its result is presented on o_res from the result register. The
// frame state is updated in that single classification step. After a LF
// completes a frame, received bytes are reported as ignored until a release
// word.

module framed_packet_receiver (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fpr_in_if.sink        i_rx,
    fpr_out_if.source     o_res
);

    logic                           r_in_valid;
    fpr_pkg::t_in_word              r_in_word;
    logic                           r_out_valid;
    fpr_pkg::t_out_word             r_out_word;

    logic [fpr_pkg::POS_W-1:0]      r_pos, n_pos;
    logic [fpr_pkg::LEN_W-1:0]      r_len, n_len;
    logic [fpr_pkg::POS_W-1:0]      r_count, n_count;
    logic [3:0]                     r_digits [fpr_pkg::DIGITS];
    logic                           r_busy, n_busy;
    logic                           r_line_end, n_line_end;
    logic                           dig_we;
    logic [1:0]                     dig_idx;
    fpr_pkg::t_out_word             n_out;
    logic                           adv;
    logic [fpr_pkg::LEN_W-1:0]      decoded;

    assign adv         = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_rx.ready  = !r_in_valid || adv;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out_word;

    assign dig_idx = r_pos[1:0] - 2'd2;
    assign decoded = fpr_pkg::LEN_W'(r_digits[0]) * fpr_pkg::LEN_W'(1000)
                   + fpr_pkg::LEN_W'(r_digits[1]) * fpr_pkg::LEN_W'(100)
                   + fpr_pkg::LEN_W'(r_digits[2]) * fpr_pkg::LEN_W'(10)
                   + fpr_pkg::LEN_W'(r_in_word.rx_value[3:0]);

    always_comb begin
        n_pos      = r_pos;
        n_len      = r_len;
        n_count    = r_count;
        n_busy     = r_busy;
        n_line_end = r_line_end;
        dig_we     = 1'b0;
        n_out      = '0;
        n_out.out_value = r_in_word.rx_value;
        if (r_in_word.mode) begin
            n_busy          = 1'b0;
            n_out.kind_code = fpr_pkg::KIND_RELEASE;
            n_out.out_value = '0;
        end else if (r_busy) begin
            n_out.kind_code = fpr_pkg::KIND_BUSY;
        end else begin
            if (r_in_word.rx_value == fpr_pkg::CH_HASH) begin
                n_len = '0;
                if (r_pos != fpr_pkg::POS_W'(1)) begin
                    n_count         = '0;
                    n_pos           = fpr_pkg::POS_W'(1);
                    n_line_end      = 1'b0;
                    n_out.kind_code = fpr_pkg::KIND_HASH1;
                end else begin
                    n_pos           = fpr_pkg::POS_FIRST_DIGIT;
                    n_out.kind_code = fpr_pkg::KIND_HASH2;
                end
            end else if (r_pos >= fpr_pkg::POS_FIRST_DIGIT
                         && r_pos <= fpr_pkg::POS_LAST_DIGIT) begin
                dig_we = 1'b1;
                if (r_pos == fpr_pkg::POS_LAST_DIGIT) begin
                    n_len   = decoded;
                    n_count = '0;
                end
                n_out.slot_index = r_pos - fpr_pkg::POS_FIRST_DIGIT;
                n_pos            = r_pos + 1'b1;
                n_out.kind_code  = fpr_pkg::KIND_DIGIT;
            end else if (r_pos >= fpr_pkg::POS_DATA && r_pos < fpr_pkg::POS_LIMIT) begin
                if (fpr_pkg::LEN_W'(r_count) < r_len) begin
                    n_out.slot_index = r_count;
                    n_count          = r_count + 1'b1;
                    n_out.kind_code  = fpr_pkg::KIND_DATA;
                end else begin
                    n_out.slot_index     = r_pos - fpr_pkg::POS_DATA
                                         - r_len[fpr_pkg::POS_W-1:0];
                    n_out.check_overflow = (n_out.slot_index >= fpr_pkg::CHECK_MAX);
                    n_out.kind_code      = fpr_pkg::KIND_CHECK;
                end
                n_pos = r_pos + 1'b1;
            end else begin
                n_pos           = '0;
                n_len           = '0;
                n_count         = '0;
                n_out.kind_code = fpr_pkg::KIND_RESET;
            end
            if (r_in_word.rx_value == fpr_pkg::CH_CR) begin
                n_pos      = n_pos + 1'b1;
                n_line_end = 1'b0;
            end
            if (r_in_word.rx_value == fpr_pkg::CH_LF && !n_line_end) begin
                n_pos            = n_pos + 1'b1;
                n_line_end       = 1'b1;
                n_busy           = 1'b1;
                n_out.frame_done = 1'b1;
            end
        end
        n_out.declared_length = n_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            r_len       <= '0;
            r_count     <= '0;
            r_busy      <= 1'b0;
            r_line_end  <= 1'b0;
            for (int i = 0; i < fpr_pkg::DIGITS; i++) begin
                r_digits[i] <= '0;
            end
        end else begin
            if (i_rx.ready) begin
                r_in_valid <= i_rx.valid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
                r_pos       <= n_pos;
                r_len       <= n_len;
                r_count     <= n_count;
                r_busy      <= n_busy;
                r_line_end  <= n_line_end;
                if (dig_we) begin
                    r_digits[dig_idx] <= r_in_word.rx_value[3:0];
                end
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_word <= i_rx.data;
        end
        if (adv) begin
            r_out_word <= n_out;
        end
    end

`ifndef ASSERT_OFF
    a_done_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && n_out.frame_done |=> r_busy)
        else $error("completed frame did not set busy");

    a_busy_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !(adv && r_in_word.mode) |=> r_busy)
        else $error("busy cleared without a release word");

    a_ovf_is_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_word.check_overflow |-> r_out_word.kind_code == fpr_pkg::KIND_CHECK)
        else $error("overflow flagged on a non-check word");

    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid && $stable(r_in_word))
        else $error("pending input word lost while stalled");
`endif

endmodule

>>> tb/tb_framed_packet_receiver.sv
// ----------------------------------------------------------------------------
// Framed packet receiver testbench
// Drives byte and release words into the receiver and compares every result
// word, field by field, with a frame tracker kept inside the testbench.
// Directed frames come first. Random frames, broken frames and noise follow,
// with random gaps on the input and stalls on the output. The run closes with
// frames sent back to back without idling.
// ----------------------------------------------------------------------------
module tb_framed_packet_receiver;

    localparam logic [fpr_pkg::POS_W-1:0] POS_HASH       = fpr_pkg::POS_W'(1);
    localparam logic [7:0]                CH_ZERO        = 8'h30;
    localparam int                        RANDOM_WORDS   = 1900;
    localparam int                        WATCHDOG_LIMIT = 500;
    localparam int                        DRAIN_CYCLES   = 10;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    fpr_in_if  rx_if ();
    fpr_out_if res_if ();

    framed_packet_receiver dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Frame tracker state.
    logic [fpr_pkg::POS_W-1:0] frm_pos    = '0;
    logic [fpr_pkg::LEN_W-1:0] len_target = '0;
    logic [fpr_pkg::POS_W-1:0] data_seen  = '0;
    logic [3:0]                len_digit [fpr_pkg::DIGITS] = '{default: '0};
    logic                      busy       = 1'b0;
    logic                      line_end   = 1'b0;

    fpr_pkg::t_out_word expected_results [$];
    int        mismatches   = 0;
    int        words_sent   = 0;
    int        gap_pct      = 0;
    int        stall_pct    = 0;
    int        stall_left   = 0;
    int        quiet_cycles = 0;
    int        idle_levels [3] = '{0, 15, 40};

    function automatic fpr_pkg::t_out_word classify_word(input fpr_pkg::t_in_word w);
        fpr_pkg::t_out_word        r;
        logic [fpr_pkg::POS_W-1:0] p;
        int                        sum;
        p = frm_pos;
        r = '0;
        r.out_value = w.rx_value;
        if (w.mode) begin
            busy = 1'b0;
            r.kind_code = fpr_pkg::KIND_RELEASE;
            r.out_value = '0;
        end else if (busy) begin
            r.kind_code = fpr_pkg::KIND_BUSY;
        end else begin
            if (w.rx_value == fpr_pkg::CH_HASH) begin
                len_target = '0;
                if (p != POS_HASH) begin
                    data_seen = '0;
                    frm_pos = POS_HASH;
                    line_end = 1'b0;
                    r.kind_code = fpr_pkg::KIND_HASH1;
                end else begin
                    frm_pos = fpr_pkg::POS_FIRST_DIGIT;
                    r.kind_code = fpr_pkg::KIND_HASH2;
                end
            end else if (p >= fpr_pkg::POS_FIRST_DIGIT && p <= fpr_pkg::POS_LAST_DIGIT) begin
                len_digit[p - fpr_pkg::POS_FIRST_DIGIT] = w.rx_value[3:0];
                if (p == fpr_pkg::POS_LAST_DIGIT) begin
                    sum = int'(len_digit[0]) * 1000 + int'(len_digit[1]) * 100
                        + int'(len_digit[2]) * 10 + int'(len_digit[3]);
                    len_target = fpr_pkg::LEN_W'(sum);
                    data_seen = '0;
                end
                r.slot_index = p - fpr_pkg::POS_FIRST_DIGIT;
                frm_pos = p + 1'b1;
                r.kind_code = fpr_pkg::KIND_DIGIT;
            end else if (p >= fpr_pkg::POS_DATA && p < fpr_pkg::POS_LIMIT) begin
                if (fpr_pkg::LEN_W'(data_seen) < len_target) begin
                    r.slot_index = data_seen;
                    data_seen = data_seen + 1'b1;
                    r.kind_code = fpr_pkg::KIND_DATA;
                end else begin
                    // The check index wraps modulo 512, so an index below zero reads large.
                    r.slot_index = fpr_pkg::POS_W'(p - fpr_pkg::POS_DATA - len_target);
                    r.check_overflow = (r.slot_index >= fpr_pkg::CHECK_MAX);
                    r.kind_code = fpr_pkg::KIND_CHECK;
                end
                frm_pos = p + 1'b1;
            end else begin
                frm_pos = '0;
                len_target = '0;
                data_seen = '0;
                r.kind_code = fpr_pkg::KIND_RESET;
            end
            if (w.rx_value == fpr_pkg::CH_CR) begin
                frm_pos = frm_pos + 1'b1;
                line_end = 1'b0;
            end
            if (w.rx_value == fpr_pkg::CH_LF && !line_end) begin
                frm_pos = frm_pos + 1'b1;
                line_end = 1'b1;
                busy = 1'b1;
                r.frame_done = 1'b1;
            end
        end
        r.declared_length = len_target;
        return r;
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == fpr_pkg::CH_HASH || b == fpr_pkg::CH_CR || b == fpr_pkg::CH_LF);
        return b;
    endfunction

    function automatic logic [7:0] noise_byte();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)
            return fpr_pkg::CH_HASH;
        else if (pick < 14)
            return fpr_pkg::CH_CR;
        else if (pick < 20)
            return fpr_pkg::CH_LF;
        else if (pick < 35)
            return CH_ZERO + 8'($urandom_range(9));
        return 8'($urandom_range(255));
    endfunction

    task automatic send_word(input logic mode, input logic [7:0] value);
        fpr_pkg::t_in_word  w;
        fpr_pkg::t_out_word r;
        w.mode = mode;
        w.rx_value = value;
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            rx_if.valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge i_clk);
        end
        rx_if.valid <= 1'b1;
        rx_if.data <= w;
        @(posedge i_clk);
        while (!rx_if.ready) @(posedge i_clk);
        r = classify_word(w);
        expected_results.push_back(r);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_frame(input int length, input int checks, input logic broken);
        logic [7:0] q [$];
        int         cut;
        q = '{fpr_pkg::CH_HASH, fpr_pkg::CH_HASH};
        q.push_back(CH_ZERO + 8'((length / 1000) % 10));
        q.push_back(CH_ZERO + 8'((length / 100) % 10));
        q.push_back(CH_ZERO + 8'((length / 10) % 10));
        q.push_back(CH_ZERO + 8'(length % 10));
        repeat (length) q.push_back(plain_byte());
        repeat (checks) q.push_back(plain_byte());
        q.push_back(fpr_pkg::CH_CR);
        q.push_back(fpr_pkg::CH_LF);
        cut = q.size();
        if (broken) begin
            q[$urandom_range(q.size() - 1)] = noise_byte();
            cut = $urandom_range(q.size() < 40 ? q.size() : 40);
        end
        for (int i = 0; i < cut; i++)
            send_word(1'b0, q[i]);
    endtask

    task automatic release_frame();
        repeat ($urandom_range(3)) send_word(1'b0, 8'($urandom_range(255)));
        if ($urandom_range(9) != 0)
            send_word(1'b1, 8'($urandom_range(255)));
    endtask

    task automatic test_release_and_stray();
        send_word(1'b1, 8'hFF);
        send_word(1'b0, 8'h41);
    endtask

    task automatic test_basic_frame();
        send_frame(0, 0, 1'b0);
        send_word(1'b1, 8'h00);
        send_word(1'b0, fpr_pkg::CH_HASH);
        send_word(1'b0, fpr_pkg::CH_HASH);
        send_word(1'b0, CH_ZERO);
        send_word(1'b0, CH_ZERO);
        send_word(1'b0, CH_ZERO);
        send_word(1'b0, CH_ZERO + 8'd1);
        send_word(1'b0, 8'hFF);
        repeat (6) send_word(1'b0, 8'h00);
        send_word(1'b0, fpr_pkg::CH_CR);
        send_word(1'b0, fpr_pkg::CH_LF);
        send_word(1'b0, fpr_pkg::CH_HASH);
        send_word(1'b1, 8'h00);
    endtask

    task automatic test_skipped_decode();
        // A CR in the last-but-one digit slot jumps over the length decode.
        send_word(1'b0, fpr_pkg::CH_HASH);
        send_word(1'b0, fpr_pkg::CH_HASH);
        send_word(1'b0, CH_ZERO + 8'd3);
        send_word(1'b0, CH_ZERO + 8'd4);
        send_word(1'b0, fpr_pkg::CH_CR);
        send_word(1'b0, fpr_pkg::CH_LF);
        send_word(1'b1, 8'h7F);
        send_word(1'b0, fpr_pkg::CH_LF);
    endtask

    task automatic test_random_traffic();
        int pick;
        int length;
        while (words_sent < RANDOM_WORDS) begin
            gap_pct = idle_levels[$urandom_range(2)];
            stall_pct = idle_levels[$urandom_range(2)];
            pick = $urandom_range(99);
            if (pick < 75) begin
                pick = $urandom_range(99);
                if (pick < 85)
                    length = $urandom_range(12);
                else if (pick < 95)
                    length = $urandom_range(80, 13);
                else
                    length = $urandom_range(299, 81);
                send_frame(length, $urandom_range(7), 1'b0);
                release_frame();
            end else if (pick < 88) begin
                send_frame($urandom_range(9999), $urandom_range(7), 1'b1);
            end else begin
                repeat ($urandom_range(10, 1))
                    send_word($urandom_range(19) == 0, noise_byte());
            end
        end
    endtask

    task automatic test_back_to_back();
        gap_pct = 0;
        stall_pct = 0;
        repeat (4) begin
            send_frame($urandom_range(8), $urandom_range(7), 1'b0);
            release_frame();
        end
        send_word(1'b1, 8'h00);
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
        end else if (!res_if.ready) begin
            res_if.ready <= 1'b1;
        end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
            res_if.ready <= 1'b0;
            stall_left = $urandom_range(2);
        end
    end

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t %s: expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        fpr_pkg::t_out_word want;
        fpr_pkg::t_out_word got;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = res_if.data;
            if (expected_results.size() == 0) begin
                mismatches++;
                $display("%0t unexpected result: expected none, got %h", $time, got);
            end else begin
                want = expected_results.pop_front();
                check_field("kind_code", want.kind_code, got.kind_code);
                check_field("out_value", want.out_value, got.out_value);
                check_field("slot_index", want.slot_index, got.slot_index);
                check_field("declared_length", want.declared_length, got.declared_length);
                check_field("frame_done", want.frame_done, got.frame_done);
                check_field("check_overflow", want.check_overflow, got.check_overflow);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no word moved for %0d cycles", $time, quiet_cycles);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : run_tests
        rx_if.valid = 1'b0;
        rx_if.data = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        gap_pct = 25;
        stall_pct = 25;
        test_release_and_stray();
        test_basic_frame();
        test_skipped_decode();
        test_random_traffic();
        test_back_to_back();
        rx_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> files.f
rtl/fpr_pkg.sv
rtl/fpr_if.sv
rtl/framed_packet_receiver.sv
tb/tb_framed_packet_receiver.sv
